[rtl/led_status_pattern_generator_top_assert.svh]
// Assertion macros used by the pattern generator core.
`ifndef LED_STATUS_PATTERN_GENERATOR_TOP_ASSERT_SVH
`define LED_STATUS_PATTERN_GENERATOR_TOP_ASSERT_SVH

// Implication checked on every clock edge, held off while in reset.
`define LSPG_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent holds.
`define LSPG_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[rtl/lspg_pkg.sv]
`default_nettype none

package lspg_pkg;

    typedef logic [3:0]  t_mode;
    typedef logic [3:0]  t_idx;
    typedef logic [10:0] t_time;

    // Request kinds carried in tuser
    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_SET_MODE = 2'd1,
        KIND_STOP     = 2'd2,
        KIND_START    = 2'd3
    } t_kind;

    // Mode codes
    localparam t_mode MODE_INIT    = 4'd0;
    localparam t_mode MODE_JOIN    = 4'd1;
    localparam t_mode MODE_CONN    = 4'd2;
    localparam t_mode MODE_ERROR   = 4'd3;
    localparam t_mode MODE_SENSOR  = 4'd4;
    localparam t_mode MODE_COMMAND = 4'd5;
    localparam t_mode MODE_SLEEP   = 4'd6;
    localparam t_mode MODE_UPDATE  = 4'd7;
    localparam t_mode MODE_OFF     = 4'd8;

    // Phase lengths in ticks
    localparam t_time LEN_100  = 11'd100;
    localparam t_time LEN_150  = 11'd150;
    localparam t_time LEN_200  = 11'd200;
    localparam t_time LEN_300  = 11'd300;
    localparam t_time LEN_500  = 11'd500;
    localparam t_time LEN_1000 = 11'd1000;
    localparam t_time LEN_2000 = 11'd2000;

    // Index of the trailing dark phase in the sensor and sleep patterns
    localparam t_idx IDX_TAIL_LONG  = 4'd6;
    // Index of the trailing dark phase in the command pattern
    localparam t_idx IDX_TAIL_SHORT = 4'd3;

    // Request and result payloads
    typedef struct packed {
        t_kind kind;
        t_mode value;
    } t_req;

    typedef struct packed {
        logic  mode_rejected;
        t_mode playing_mode;
        logic  led_level;
    } t_res;

    // Number of phases in each pattern
    function automatic t_idx phase_count(input t_mode m);
        t_idx c;
        case (m)
            MODE_ERROR:   c = 4'd10;
            MODE_SENSOR:  c = 4'd7;
            MODE_COMMAND: c = 4'd4;
            MODE_SLEEP:   c = 4'd7;
            MODE_OFF:     c = 4'd1;
            default:      c = 4'd2;
        endcase
        return c;
    endfunction

    // Length of one phase
    function automatic t_time phase_len(input t_mode m, input t_idx p);
        t_time l;
        case (m)
            MODE_INIT:    l = LEN_200;
            MODE_JOIN:    l = LEN_500;
            MODE_CONN:    l = LEN_2000;
            MODE_ERROR:   l = p[0] ? LEN_200 : LEN_100;
            MODE_SENSOR:  l = (p == IDX_TAIL_LONG) ? LEN_500 : LEN_100;
            MODE_COMMAND: l = (p == IDX_TAIL_SHORT) ? LEN_500 : LEN_100;
            MODE_SLEEP:   l = (p == IDX_TAIL_LONG) ? LEN_1000 : LEN_150;
            MODE_UPDATE:  l = p[0] ? LEN_100 : LEN_300;
            default:      l = LEN_1000;
        endcase
        return l;
    endfunction

    // LED level of one phase: lit on even phases, save the dark tails and mode off
    function automatic logic phase_lit(input t_mode m, input t_idx p);
        logic lit;
        if (m == MODE_OFF) begin
            lit = 1'b0;
        end else if ((m == MODE_SENSOR || m == MODE_SLEEP) && p == IDX_TAIL_LONG) begin
            lit = 1'b0;
        end else begin
            lit = ~p[0];
        end
        return lit;
    endfunction

endpackage

`default_nettype wire

[rtl/lspg_core.sv]
`default_nettype none

module lspg_core
    import lspg_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_en,
    input  t_req i_req,
    output t_res o_res
);

    `include "led_status_pattern_generator_top_assert.svh"

    t_mode r_requested, n_requested;
    t_mode r_active,    n_active;
    t_idx  r_idx,       n_idx;
    t_time r_time,      n_time;
    logic  r_running,   n_running;
    logic  r_led,       n_led;
    logic  w_rejected;

    t_time w_time_dec;
    t_idx  w_idx_inc;

    assign w_time_dec = (r_time != '0) ? r_time - 11'd1 : '0;
    assign w_idx_inc  = r_idx + 4'd1;

    // Next state for the request at the input
    always_comb begin
        n_requested = r_requested;
        n_active    = r_active;
        n_idx       = r_idx;
        n_time      = r_time;
        n_running   = r_running;
        n_led       = r_led;
        w_rejected  = 1'b0;
        unique case (i_req.kind)
            KIND_TICK: begin
                if (r_running) begin
                    n_time = w_time_dec;
                    if (w_time_dec == '0) begin
                        if (w_idx_inc >= phase_count(r_active)) begin
                            // pattern done: adopt the requested mode
                            n_active = r_requested;
                            n_idx    = '0;
                            n_led    = phase_lit(r_requested, '0);
                            n_time   = phase_len(r_requested, '0);
                        end else begin
                            n_idx  = w_idx_inc;
                            n_led  = phase_lit(r_active, w_idx_inc);
                            n_time = phase_len(r_active, w_idx_inc);
                        end
                    end
                end
            end
            KIND_SET_MODE: begin
                if (i_req.value <= MODE_OFF) begin
                    n_requested = i_req.value;
                end else begin
                    w_rejected = 1'b1;
                end
            end
            KIND_STOP: begin
                n_running = 1'b0;
                n_led     = 1'b0;
            end
            KIND_START: begin
                if (!r_running) begin
                    n_running = 1'b1;
                    n_active  = r_requested;
                    n_idx     = '0;
                    n_led     = phase_lit(r_requested, '0);
                    n_time    = phase_len(r_requested, '0);
                end
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_requested <= MODE_OFF;
            r_active    <= MODE_OFF;
            r_idx       <= '0;
            r_time      <= LEN_1000;
            r_running   <= 1'b1;
            r_led       <= 1'b0;
        end else if (i_en) begin
            r_requested <= n_requested;
            r_active    <= n_active;
            r_idx       <= n_idx;
            r_time      <= n_time;
            r_running   <= n_running;
            r_led       <= n_led;
        end
    end

    // Result of this request
    assign o_res.led_level     = n_led;
    assign o_res.playing_mode  = n_active;
    assign o_res.mode_rejected = w_rejected;

    `LSPG_ASSERT_IMPL(a_idx_in_pattern, 1'b1, r_idx < phase_count(r_active),
        "phase index beyond pattern")
    `LSPG_ASSERT_IMPL(a_dark_when_stopped, !r_running, !r_led,
        "LED lit while stopped")
    `LSPG_ASSERT_IMPL(a_modes_valid, 1'b1, r_requested <= MODE_OFF && r_active <= MODE_OFF,
        "mode register out of range")
    `LSPG_ASSERT_NEXT(a_frozen_when_idle, !i_en, $stable(r_time) && $stable(r_idx),
        "state moved without a request")

endmodule

`default_nettype wire

[rtl/led_status_pattern_generator_top.sv]
// Status LED pattern generator, one request per 1 ms tick or command.
// Path: input register, core logic, then result register; m_axis_tready can stall in between.
// Throughput: one request per cycle; the only stalls come from m_axis_tready.
// Reset (synchronous, i_rst_n low): mode off, first off phase of 1000 ticks loaded,
// pattern running, LED dark, both register stages empty.
`default_nettype none

module led_status_pattern_generator_top
    import lspg_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [3:0] mode_value, [7:4] zero
    input  wire  [1:0] s_axis_tuser,   // [1:0] kind
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] led_level, [4:1] playing_mode, [5] mode_rejected
);

    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    t_res r_out;
    logic w_out_free;
    logic w_adv;
    t_res w_res;

    // Pipeline moves when the result register can take a new entry
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.kind  <= t_kind'(s_axis_tuser);
            r_in.value <= s_axis_tdata[3:0];
        end
    end

    lspg_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_req   (r_in),
        .o_res   (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out};

endmodule

`default_nettype wire
